>>> sv/fconv_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fconv_pkg
// Shared constants and types for the FIR convolution unit.
// ----------------------------------------------------------------------------
package fconv_pkg;

    // Sizes
    localparam int MAX_TAPS       = 64;
    localparam int SAMPLE_BITS    = 16;
    localparam int OUT_BITS       = 38;
    localparam int TAP_IDX_BITS   = 6;
    localparam int TAP_COUNT_BITS = 7;

    // Exact accumulator width, never narrower than the result
    localparam int ACC_BITS = 2 * SAMPLE_BITS + $clog2(MAX_TAPS);
    localparam int SUM_BITS = (ACC_BITS > OUT_BITS) ? ACC_BITS : OUT_BITS;

    // Stream packing
    localparam int S_TDATA_BITS = ((TAP_IDX_BITS + SAMPLE_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((OUT_BITS + 7) / 8) * 8;

    // Command codes carried on s_tuser
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_LOAD   = 1'b1;

    // Broadcast control to every cell
    typedef struct packed {
        logic                          shift;  // advance the delay line
        logic                          load;   // tap write transaction
        logic signed [SAMPLE_BITS-1:0] value;  // sample or coefficient
    } cell_ctrl_t;

endpackage

>>> sv/fconv_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fconv_cell
// One tap of the FIR chain: holds a delay-line sample and a coefficient,
// forms their product and adds it to the partial sum from its right-hand
// neighbour.
// ----------------------------------------------------------------------------
module fconv_cell (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  fconv_pkg::cell_ctrl_t                 ctrl,
    input  logic                                  load_sel,
    input  logic                                  active,
    input  logic signed [fconv_pkg::SAMPLE_BITS-1:0] sample_in,
    input  logic signed [fconv_pkg::SUM_BITS-1:0]    psum_in,
    output logic signed [fconv_pkg::SAMPLE_BITS-1:0] sample_out,
    output logic signed [fconv_pkg::SUM_BITS-1:0]    psum_out
);
    import fconv_pkg::*;

    logic signed [SAMPLE_BITS-1:0]   sample_reg;
    logic signed [SAMPLE_BITS-1:0]   tap_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_reg;
    logic signed [2*SAMPLE_BITS-1:0] prod_next;
    logic signed [SUM_BITS-1:0]      psum_reg;
    logic signed [SUM_BITS-1:0]      psum_next;

    // Delay-line stage and coefficient store
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sample_reg <= '0;
            tap_reg    <= '0;
        end else begin
            if (ctrl.shift) begin
                sample_reg <= sample_in;
            end
            if (ctrl.load && load_sel) begin
                tap_reg <= ctrl.value;
            end
        end
    end

    // Masked product (kept signed), then add into the chain
    always_comb begin
        if (active) begin
            prod_next = sample_reg * tap_reg;
        end else begin
            prod_next = '0;
        end
        psum_next = SUM_BITS'(prod_reg) + psum_in;
    end

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    assign sample_out = sample_reg;
    assign psum_out   = psum_reg;

endmodule

>>> sv/fir_convolution_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fir_convolution_unit
// Direct-form FIR filter built from a row of tap cells. Load transactions
// write one coefficient; sample transactions shift the delay line and return
// the exact, saturated convolution sum.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_*       in         tuser: command; tdata: tap_index, value
//  m_*       out        tdata: filtered_value (Q8.30)
//  cfg_*     in         tap_count write
//
//  A load transaction does not hold the block. A sample transaction holds
//  it busy while the partial sum ripples one cell per cycle along the row.
//  s_tready is low meanwhile, and also while a finished sum waits for a
//  previous result still unclaimed on m_*.
//  Reset clears delay line and coefficients and sets tap_count to 64.
// ----------------------------------------------------------------------------
module fir_convolution_unit (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    // input stream
    input  logic                                    s_tvalid,
    output logic                                    s_tready,
    input  logic [fconv_pkg::S_TDATA_BITS-1:0]      s_tdata,   // [5:0] tap_index, [21:6] value
    input  logic                                    s_tuser,   // [0] command
    // result stream
    output logic                                    m_tvalid,
    input  logic                                    m_tready,
    output logic [fconv_pkg::M_TDATA_BITS-1:0]      m_tdata,   // [37:0] filtered_value
    // configuration
    input  logic                                    cfg_wen,
    input  logic [fconv_pkg::TAP_COUNT_BITS-1:0]    cfg_wdata
);
    import fconv_pkg::*;

    localparam int SETTLE   = MAX_TAPS + 2;
    localparam int CNT_BITS = $clog2(SETTLE + 1);

    localparam logic signed [SUM_BITS-1:0] SUM_HI =
        ({{(SUM_BITS-1){1'b0}}, 1'b1} << (OUT_BITS - 1)) - 1'b1;
    localparam logic signed [SUM_BITS-1:0] SUM_LO = ~SUM_HI;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BUSY
    } state_t;

    state_t                        state_reg;
    logic [CNT_BITS-1:0]           cnt_reg;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [OUT_BITS-1:0]           m_data_reg;
    logic [TAP_COUNT_BITS-1:0]     tap_count_reg;

    logic                          s_accept;
    logic [TAP_IDX_BITS-1:0]       s_tap_index;
    logic signed [SAMPLE_BITS-1:0] s_value;
    logic                          done;
    logic                          slot_free;
    logic [OUT_BITS-1:0]           result;
    cell_ctrl_t                    ctrl;

    logic signed [SAMPLE_BITS-1:0] sample_chain [MAX_TAPS+1];
    logic signed [SUM_BITS-1:0]    psum_chain   [MAX_TAPS+1];

    // Input unpacking
    assign s_tap_index = s_tdata[TAP_IDX_BITS-1:0];
    assign s_value     = s_tdata[TAP_IDX_BITS +: SAMPLE_BITS];
    assign s_tready    = (state_reg == ST_IDLE);
    assign s_accept    = s_tvalid && s_tready;

    assign ctrl = '{
        shift: s_accept && (s_tuser == CMD_SAMPLE),
        load:  s_accept && (s_tuser == CMD_LOAD),
        value: s_value
    };

    // Tap count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tap_count_reg <= TAP_COUNT_BITS'(64);
        end else if (cfg_wen) begin
            tap_count_reg <= cfg_wdata;
        end
    end

    // Cell row
    assign sample_chain[0]        = s_value;
    assign psum_chain[MAX_TAPS]   = '0;

    for (genvar k = 0; k < MAX_TAPS; k++) begin : g_cell
        logic load_sel;
        logic active;

        assign load_sel = (32'(s_tap_index) == k);
        // zero count acts as one; counts past the row enable every cell
        assign active   = (tap_count_reg == '0) ? (k == 0) : (32'(tap_count_reg) > k);

        fconv_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .load_sel   (load_sel),
            .active     (active),
            .sample_in  (sample_chain[k]),
            .psum_in    (psum_chain[k+1]),
            .sample_out (sample_chain[k+1]),
            .psum_out   (psum_chain[k])
        );
    end

    // Saturate the full sum into the output range
    always_comb begin
        if (psum_chain[0] > SUM_HI) begin
            result = SUM_HI[OUT_BITS-1:0];
        end else if (psum_chain[0] < SUM_LO) begin
            result = SUM_LO[OUT_BITS-1:0];
        end else begin
            result = psum_chain[0][OUT_BITS-1:0];
        end
    end

    assign slot_free = !m_tvalid_reg || m_tready;
    assign done      = (cnt_reg == CNT_BITS'(SETTLE)) && slot_free;

    // Result valid: cleared when taken, set when a new sum lands
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        if ((state_reg == ST_BUSY) && done) begin
            m_tvalid_next = 1'b1;
        end
    end

    // Sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (ctrl.shift) begin
                        state_reg <= ST_BUSY;
                    end
                end
                ST_BUSY: begin
                    if (done) begin
                        m_data_reg   <= result;
                        state_reg    <= ST_IDLE;
                    end else if (cnt_reg != CNT_BITS'(SETTLE)) begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_BITS'(m_data_reg);

endmodule
